FILE: design/acl_pkg.sv
package acl_pkg;

  // operation codes carried in the low bits of in_tuser
  typedef enum logic [1:0] {
    FN_CLEAR      = 2'd0,
    FN_ADD_MASK   = 2'd1,
    FN_ADD_PREFIX = 2'd2,
    FN_QUERY      = 2'd3
  } acl_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } acl_state_t;

  localparam logic FAM_IPV4 = 1'b0;

  localparam int V4_BITS  = 32;
  localparam int HALF_BITS = 64;

  localparam logic [7:0] PREFIX_V4_MAX = 8'd32;
  localparam logic [7:0] PREFIX_V6_MAX = 8'd128;

  localparam int IN_TDATA_W  = 264;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int COUNT_OUT_W = 5;

  typedef struct packed {
    logic        family;
    logic [63:0] net_high;
    logic [63:0] net_low;
    logic [63:0] mask_high;
    logic [63:0] mask_low;
  } acl_entry_t;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } acl_key_t;

endpackage

FILE: design/acl_table.sv
module acl_table
  import acl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  acl_entry_t       wr_entry,
  input  logic [IDX_W-1:0] rd_idx,
  output acl_entry_t       rd_entry
);

  acl_entry_t mem [TABLE_ENTRIES];
  acl_entry_t rd_entry_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry_r <= mem[rd_idx];
  end

  assign rd_entry = rd_entry_r;

endmodule

FILE: design/acl_match.sv
module acl_match
  import acl_pkg::*;
(
  input  acl_key_t   key,
  input  acl_entry_t entry,
  output logic       hit
);

  logic fam_eq;
  logic high_eq;
  logic low_eq;

  // shared compare unit: (address and mask) against network, same family
  always_comb begin
    fam_eq  = (entry.family == key.family);
    high_eq = ((key.addr_high & entry.mask_high) == entry.net_high);
    low_eq  = ((key.addr_low & entry.mask_low) == entry.net_low);
    hit     = fam_eq && high_eq && low_eq;
  end

endmodule

FILE: design/ip_network_access_list.sv
// channel | dir | tdata (lowest bit up)                         | tuser
// --------+-----+-----------------------------------------------+---------------------
// in_     | in  | addr_high, addr_low, mask_high, mask_low,     | func[1:0], family[2]
//         |     | prefix_len (264 bits)                         |
// out_    | out | granted, table_full, entry_count, zero pad    | none
//
// clear and add words pass from EXEC to DONE, and DONE loads the result register once it is free
// a query walks the table one entry per cycle through a single comparator,
//   stopping at the first hit; on an empty table it goes straight from EXEC to DONE
// in_tready is high only while the sequencer is idle; one word is in flight at a time
// a held result register lets the next word be accepted while out_tvalid waits
// synchronous active-low reset empties the table; entry contents are not cleared
module ip_network_access_list
  import acl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // addr_high, addr_low, mask_high, mask_low, prefix_len
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // func, family
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // granted, table_full, entry_count, zero pad
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // input word fields
  acl_func_t   in_func;
  logic        in_family;
  logic [63:0] in_addr_high;
  logic [63:0] in_addr_low;
  logic [63:0] in_mask_high;
  logic [63:0] in_mask_low;
  logic [7:0]  in_prefix_len;
  logic        in_fire;

  assign in_func       = acl_func_t'(in_tuser[1:0]);
  assign in_family     = in_tuser[2];
  assign in_addr_high  = in_tdata[63:0];
  assign in_addr_low   = in_tdata[127:64];
  assign in_mask_high  = in_tdata[191:128];
  assign in_mask_low   = in_tdata[255:192];
  assign in_prefix_len = in_tdata[263:256];

  // control and operand registers
  acl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  acl_func_t        op_func_r;
  acl_key_t         op_key_r;
  logic [63:0]      op_mask_high_r;
  logic [63:0]      op_mask_low_r;
  logic             res_granted_r, res_granted_nxt;
  logic             res_full_r, res_full_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_granted_r;
  logic                   out_full_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  // operand shaping at acceptance
  logic [7:0]  prefix_sat;
  logic [63:0] pfx_mask_high;
  logic [63:0] pfx_mask_low;
  acl_key_t    key_in;
  logic [63:0] mask_high_in;
  logic [63:0] mask_low_in;

  // table and compare unit
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  acl_entry_t       wr_entry;
  logic [IDX_W-1:0] rd_idx;
  acl_entry_t       rd_entry;
  logic             hit;

  logic table_full_w;
  logic walk_last_w;
  logic out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // prefix length to thermometer mask, saturated to the family width
  always_comb begin
    pfx_mask_high = '0;
    pfx_mask_low  = '0;
    if (in_family == FAM_IPV4) begin
      prefix_sat = (in_prefix_len > PREFIX_V4_MAX) ? PREFIX_V4_MAX : in_prefix_len;
      for (int j = 0; j < V4_BITS; j++) begin
        pfx_mask_low[V4_BITS-1-j] = (8'(j) < prefix_sat);
      end
    end else begin
      prefix_sat = (in_prefix_len > PREFIX_V6_MAX) ? PREFIX_V6_MAX : in_prefix_len;
      for (int j = 0; j < HALF_BITS; j++) begin
        pfx_mask_high[HALF_BITS-1-j] = (8'(j) < prefix_sat);
        pfx_mask_low[HALF_BITS-1-j]  = (8'(j + HALF_BITS) < prefix_sat);
      end
    end
  end

  // ipv4 uses the low 32 bits only
  always_comb begin
    key_in.family = in_family;
    if (in_func == FN_ADD_PREFIX) begin
      mask_high_in = pfx_mask_high;
      mask_low_in  = pfx_mask_low;
    end else begin
      mask_high_in = in_mask_high;
      mask_low_in  = in_mask_low;
    end
    if (in_family == FAM_IPV4) begin
      key_in.addr_high = '0;
      key_in.addr_low  = {32'd0, in_addr_low[V4_BITS-1:0]};
      mask_high_in     = '0;
      mask_low_in      = {32'd0, mask_low_in[V4_BITS-1:0]};
    end else begin
      key_in.addr_high = in_addr_high;
      key_in.addr_low  = in_addr_low;
    end
  end

  assign table_full_w = (count_r == CNT_W'(TABLE_ENTRIES));
  assign walk_last_w  = ((CNT_W'(ptr_r) + CNT_W'(1)) == count_r);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign wr_idx   = count_r[IDX_W-1:0];
  assign wr_entry = '{family:    op_key_r.family,
                      net_high:  op_key_r.addr_high,
                      net_low:   op_key_r.addr_low,
                      mask_high: op_mask_high_r,
                      mask_low:  op_mask_low_r};
  // prefetch: entry 0 on entering the walk, the next entry while walking
  assign rd_idx   = (state_r == ST_WALK) ? (ptr_r + IDX_W'(1)) : '0;

  acl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  acl_match u_match (
    .key   (op_key_r),
    .entry (rd_entry),
    .hit   (hit)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_func_r == FN_QUERY && count_r != '0) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (hit || walk_last_w) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    res_granted_nxt = res_granted_r;
    res_full_nxt    = res_full_r;
    wr_en           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        res_granted_nxt = 1'b0;
        res_full_nxt    = 1'b0;
      end
      ST_EXEC: begin
        ptr_nxt = '0;
        case (op_func_r) inside
          FN_CLEAR: begin
            count_nxt = '0;
          end
          FN_ADD_MASK, FN_ADD_PREFIX: begin
            if (table_full_w) begin
              res_full_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          default: begin
            // empty table grants everything
            res_granted_nxt = (count_r == '0);
          end
        endcase
      end
      ST_WALK: begin
        if (hit) begin
          res_granted_nxt = 1'b1;
        end
        ptr_nxt = ptr_r + IDX_W'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    res_granted_r <= res_granted_nxt;
    res_full_r    <= res_full_nxt;
    if (in_fire) begin
      op_func_r      <= in_func;
      op_key_r       <= key_in;
      op_mask_high_r <= mask_high_in;
      op_mask_low_r  <= mask_low_in;
    end
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_full_r    <= res_full_r;
      out_count_r   <= COUNT_OUT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_full_r, out_granted_r};

  // the count never runs past the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  // writes only land on a free slot
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !table_full_w && state_r == ST_EXEC)
    else $error("table write while full");

  // the walk stays within the valid entries
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> CNT_W'(ptr_r) < count_r)
    else $error("walk pointer past valid entries");

  // only a query can grant, only an add can flag full
  a_grant_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_granted_r |-> op_func_r == FN_QUERY)
    else $error("grant on a non-query word");

  a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_full_r |->
      (op_func_r == FN_ADD_MASK || op_func_r == FN_ADD_PREFIX) && table_full_w)
    else $error("table full flag without a dropped add");

endmodule
